FILE: design/gmd_pkg.sv
package gmd_pkg;

  localparam int unsigned FreqW  = 16;
  localparam int unsigned DataW  = 16;
  localparam int unsigned MdW    = 24;
  localparam int unsigned FracW  = 8;
  localparam int unsigned TotW   = 25;   // covers up to 512 classes
  localparam int unsigned WsumW  = 42;
  localparam int unsigned DsumW  = 42;
  localparam int unsigned QuotW  = DsumW + FracW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_MEAN,
    ST_WALK,
    ST_DIV_DEV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;      // accept a class into table and sums
    logic mean_start;
    logic walk_start;
    logic walk_step;
    logic dev_start;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic walk_last;
    logic zero_total;
  } stat_t;

endpackage

FILE: design/gmd_ram.sv
module gmd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: design/gmd_div.sv
// unsigned restoring divider, one quotient bit per cycle
module gmd_div #(
  parameter int unsigned NumW = 50,
  parameter int unsigned DenW = 25
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

FILE: design/gmd_ctrl.sv
module gmd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           last_class_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gmd_pkg::ctrl_t ctrl_o,
  input  gmd_pkg::stat_t stat_i
);
  import gmd_pkg::*;

  state_e state_q, state_d;
  logic   acc;

  assign acc = in_valid_i && state_q == ST_LOAD;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && last_class_i) begin
          state_d = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (stat_i.zero_total) begin
          state_d = ST_OUT;
        end else if (stat_i.div_done) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat_i.walk_last) begin
          state_d = ST_DIV_DEV;
        end
      end
      ST_DIV_DEV: begin
        if (stat_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != ST_LOAD;
    out_valid_o = state_q == ST_OUT;
    ctrl_o = '0;
    ctrl_o.load = acc;
    ctrl_o.mean_start = acc && last_class_i;
    ctrl_o.walk_start = state_q == ST_DIV_MEAN && stat_i.div_done;
    ctrl_o.walk_step = state_q == ST_WALK;
    ctrl_o.dev_start = state_q == ST_WALK && stat_i.walk_last;
    ctrl_o.clear = state_q == ST_OUT && !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_LOAD |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_class_i |=> state_q == ST_DIV_MEAN) else $error("series not closed");
endmodule

FILE: design/gmd_dp.sv
module gmd_dp #(
  parameter int unsigned MaxClasses = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gmd_pkg::ctrl_t              ctrl_i,
  output gmd_pkg::stat_t              stat_o,
  input  logic signed [15:0]          lower_limit_i,
  input  logic signed [15:0]          upper_limit_i,
  input  logic [15:0]                 frequency_i,
  output logic [23:0]                 mean_deviation_o,
  output logic signed [15:0]          series_mean_o,
  output logic                        divide_error_o,
  output logic                        overflow_o
);
  import gmd_pkg::*;

  localparam int unsigned AddrW = (MaxClasses > 1) ? $clog2(MaxClasses) : 1;
  localparam int unsigned CntW  = $clog2(MaxClasses + 1);

  logic [CntW-1:0]         count_q, count_d;
  logic [TotW-1:0]         total_q, total_d;
  logic signed [WsumW-1:0] wsum_q, wsum_d;
  logic [DsumW-1:0]        dsum_q, dsum_d;
  logic                    drop_q, drop_d;
  logic                    neg_q;
  logic signed [15:0]      mean_q;
  logic [CntW-1:0]         rd_q;    // read address issued
  logic                    pv_q;    // read data valid
  logic [CntW-1:0]         seen_q;  // entries summed
  logic [23:0]             md_q;

  logic signed [16:0] sum17;
  logic signed [15:0] mid;
  logic               room;
  logic [DataW-1:0]   mid_rd;
  logic [FreqW-1:0]   frq_rd;
  logic [QuotW-1:0]   div_num, quot;
  logic               div_start, div_done;
  logic [WsumW-1:0]   wabs;
  logic signed [17:0] diff;
  logic [16:0]        adist;
  logic [33:0]        prod;

  assign sum17 = 17'(lower_limit_i) + 17'(upper_limit_i);
  // truncate toward zero: bias negative odd sums up before the shift
  assign mid   = 16'((sum17 + 17'(sum17[16])) >>> 1);
  assign room  = count_q < CntW'(MaxClasses);

  gmd_ram #(.Width(DataW), .Depth(MaxClasses)) u_mid_ram (
    .clk_i, .we_i(ctrl_i.load && room), .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(mid), .raddr_i(rd_q[AddrW-1:0]), .rdata_o(mid_rd));
  gmd_ram #(.Width(FreqW), .Depth(MaxClasses)) u_frq_ram (
    .clk_i, .we_i(ctrl_i.load && room), .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(frequency_i), .raddr_i(rd_q[AddrW-1:0]), .rdata_o(frq_rd));

  assign wabs = wsum_d[WsumW-1] ? WsumW'(-wsum_d) : WsumW'(wsum_d);
  // no mean division for an empty series, so the divider stays idle
  assign div_start = (ctrl_i.mean_start && total_d != '0) || ctrl_i.dev_start;
  assign div_num = ctrl_i.mean_start ? QuotW'(wabs) : {dsum_d, {FracW{1'b0}}};

  gmd_div #(.NumW(QuotW), .DenW(TotW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(total_d),
    .done_o(div_done), .quot_o(quot));

  assign diff  = 18'($signed(mid_rd)) - 18'(mean_q);
  assign adist = diff[17] ? 17'(-diff) : 17'(diff);

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    wsum_d  = wsum_q;
    drop_d  = drop_q;
    dsum_d  = dsum_q;
    prod    = 34'(adist) * 34'(frq_rd);
    if (ctrl_i.load) begin
      if (room) begin
        count_d = count_q + 1'b1;
        total_d = total_q + TotW'(frequency_i);
        wsum_d  = wsum_q + WsumW'(mid) * $signed({1'b0, frequency_i});
      end else begin
        drop_d = 1'b1;
      end
    end
    if (ctrl_i.walk_start) begin
      dsum_d = '0;
    end else if (pv_q) begin
      dsum_d = dsum_q + DsumW'(prod);
    end
    if (ctrl_i.clear) begin
      count_d = '0;
      total_d = '0;
      wsum_d  = '0;
      drop_d  = 1'b0;
      dsum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      wsum_q  <= '0;
      dsum_q  <= '0;
      drop_q  <= 1'b0;
      rd_q    <= '0;
      pv_q    <= 1'b0;
      seen_q  <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
      wsum_q  <= wsum_d;
      dsum_q  <= dsum_d;
      drop_q  <= drop_d;
      if (ctrl_i.walk_start) begin
        rd_q   <= '0;
        seen_q <= '0;
        pv_q   <= 1'b0;
      end else if (ctrl_i.walk_step) begin
        pv_q <= rd_q < count_q;
        if (rd_q < count_q) begin
          rd_q <= rd_q + 1'b1;
        end
        if (pv_q) begin
          seen_q <= seen_q + 1'b1;
        end
      end else begin
        pv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mean_start) begin
      neg_q <= wsum_d[WsumW-1];
    end
    if (ctrl_i.walk_start) begin
      mean_q <= neg_q ? 16'(-quot) : 16'(quot);
    end
    if (ctrl_i.mean_start && total_d == '0) begin
      mean_q <= '0;
      md_q   <= '0;
    end else if (ctrl_i.walk_step && stat_o.walk_last) begin
      md_q <= '0;
    end else if (div_done && !ctrl_i.walk_start) begin
      md_q <= (quot > QuotW'(24'hFFFFFF)) ? 24'hFFFFFF : quot[23:0];
    end
  end

  assign stat_o.div_done   = div_done;
  assign stat_o.zero_total = total_q == '0;
  assign stat_o.walk_last  = ctrl_i.walk_step && pv_q && seen_q + 1'b1 == count_q;

  assign mean_deviation_o = md_q;
  assign series_mean_o    = mean_q;
  assign divide_error_o   = total_q == '0;
  assign overflow_o       = drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxClasses)) else $error("class count past table");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> count_q == '0 && total_q == '0 && !drop_q) else $error("not cleared");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load && !room && !ctrl_i.clear |=> drop_q) else $error("drop not flagged");
endmodule

FILE: design/grouped_mean_deviation_from_mean_top.sv
// Mean absolute deviation of a grouped series.
// Input channel: one class per transaction (lower_limit_i, upper_limit_i,
// frequency_i, last_class_i), handshake in_valid_i / in_stall_o.
// Classes are taken one per cycle while loading; a series may hold up to
// MAX_CLASSES classes, later ones are dropped and flag overflow_o.
// A class with last_class_i closes the series and yields one result on
// the output channel (out_valid_o / out_stall_i): mean_deviation_o with
// 8 fraction bits, series_mean_o, divide_error_o and overflow_o.
// The result follows two radix-2 divisions of a 50-bit dividend, one for
// the mean and one for the deviation, with a walk over the stored class
// table between them.
// With zero total frequency both divisions and the walk are skipped.
// While busy or holding a result in_stall_o is high. A stalled result holds
// until taken; then all sums clear and the next class is taken from the
// following cycle on.
// Reset (rst_ni low, asynchronous) empties the series and drops any result.
module grouped_mean_deviation_from_mean_top #(
  parameter int unsigned MAX_CLASSES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] lower_limit_i,
  input  logic signed [15:0] upper_limit_i,
  input  logic [15:0]        frequency_i,
  input  logic               last_class_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [23:0]        mean_deviation_o,
  output logic signed [15:0] series_mean_o,
  output logic               divide_error_o,
  output logic               overflow_o
);
  import gmd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  gmd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .last_class_i,
    .out_valid_o, .out_stall_i, .ctrl_o(ctrl), .stat_i(stat));

  gmd_dp #(.MaxClasses(MAX_CLASSES)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .lower_limit_i, .upper_limit_i, .frequency_i,
    .mean_deviation_o, .series_mean_o, .divide_error_o, .overflow_o);
endmodule
